@@ hdl/ecm_pkg.sv @@
// ----------------------------------------------------------------------------
// ecm_pkg
// shared types and constants of the ease curve multiplier
// ----------------------------------------------------------------------------
package ecm_pkg;

    // configuration register indexes
    localparam logic [2:0] REG_IN_START  = 3'd0;
    localparam logic [2:0] REG_IN_END    = 3'd1;
    localparam logic [2:0] REG_OUT_START = 3'd2;
    localparam logic [2:0] REG_OUT_END   = 3'd3;
    localparam logic [2:0] REG_IN_CURVE  = 3'd4;
    localparam logic [2:0] REG_OUT_CURVE = 3'd5;
    localparam logic [2:0] REG_MODE      = 3'd6;

    // register reset values
    localparam logic [31:0] IN_CURVE_RESET  = 32'hFFFF_0000;
    localparam logic [31:0] OUT_CURVE_RESET = 32'h0000_FFFF;

    // 1.0 in q1.16
    localparam logic [16:0] ONE_Q16 = 17'h1_0000;

    // quotient bits of the span division
    localparam int unsigned QBITS = 17;

    // rounding offset of the curve sum: half of 255 * 2^32
    localparam logic [56:0] CURVE_RND = 57'd255 << 31;

    // rounding offset of the cross-fade sum
    localparam logic [23:0] FADE_RND = 24'd127;

    // reciprocal of 255 scaled by 2^33, rounded up; exact for values below 2^24
    localparam logic [25:0] RECIP_255 = 26'd33686019;
    localparam int unsigned RECIP_SHIFT = 33;

    // what an item resolves to
    typedef enum logic [1:0] {
        KIND_CONST = 2'd0,
        KIND_IN    = 2'd1,
        KIND_OUT   = 2'd2,
        KIND_FADE  = 2'd3
    } kind_t;

    // control that travels with each item down the pipeline
    typedef struct packed {
        logic  valid;
        kind_t kind;
        logic  t_zero;
        logic  t_one;
    } tag_t;

    // configuration register file
    typedef struct packed {
        logic signed [31:0] in_start;
        logic signed [31:0] in_end;
        logic signed [31:0] out_start;
        logic signed [31:0] out_end;
        logic [31:0]        in_curve;
        logic [31:0]        out_curve;
        logic [1:0]         mode;
    } cfg_t;

endpackage

@@ hdl/ecm_span.sv @@
// ----------------------------------------------------------------------------
// ecm_span
// picks the segment for an item and forms the span numerator and divisor
// ----------------------------------------------------------------------------
module ecm_span
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  logic signed [31:0]  now_clock,
    input  ecm_pkg::cfg_t       cfg,
    output ecm_pkg::tag_t       tag,
    output logic [32:0]         num,
    output logic [32:0]         den
);

    logic signed [32:0] now_x;
    logic signed [32:0] in_start_x;
    logic signed [32:0] in_end_x;
    logic signed [32:0] out_start_x;
    logic signed [32:0] out_end_x;
    logic               ein;
    logic               eout;
    logic               both;
    ecm_pkg::kind_t     kind_a;
    logic signed [33:0] n_a;
    logic signed [33:0] d_a;

    ecm_pkg::tag_t      tag_a_reg;
    logic signed [33:0] n_a_reg;
    logic signed [33:0] d_a_reg;

    logic signed [33:0] n_b;
    logic signed [33:0] d_b;
    logic               zero_b;
    logic               one_b;
    ecm_pkg::tag_t      tag_b_next;

    ecm_pkg::tag_t      tag_b_reg;
    logic [32:0]        n_b_reg;
    logic [32:0]        d_b_reg;

    assign now_x       = {now_clock[31], now_clock};
    assign in_start_x  = {cfg.in_start[31], cfg.in_start};
    assign in_end_x    = {cfg.in_end[31], cfg.in_end};
    assign out_start_x = {cfg.out_start[31], cfg.out_start};
    assign out_end_x   = {cfg.out_end[31], cfg.out_end};
    assign ein         = cfg.mode[0];
    assign eout        = cfg.mode[1];
    assign both        = ein && eout && (cfg.in_start >= cfg.out_start);

    // segment select
    always_comb
    begin
        kind_a = ecm_pkg::KIND_CONST;
        if (both)
        begin
            if (now_clock > cfg.out_end)
            begin
                if (now_clock > cfg.in_start)
                begin
                    if (now_clock <= cfg.in_end)
                        kind_a = ecm_pkg::KIND_IN;
                end
                else
                    kind_a = ecm_pkg::KIND_FADE;
            end
            else
                kind_a = ecm_pkg::KIND_OUT;
        end
        else
        begin
            if (eout && (now_clock >= cfg.out_start))
                kind_a = ecm_pkg::KIND_OUT;
            if (ein && (now_clock <= cfg.in_end))
                kind_a = ecm_pkg::KIND_IN;
        end
    end

    // signed span differences, exact in 33 bits
    always_comb
    begin
        case (kind_a)
            ecm_pkg::KIND_IN:
            begin
                n_a = 34'(now_x - in_start_x);
                d_a = 34'(in_end_x - in_start_x);
            end
            ecm_pkg::KIND_FADE:
            begin
                n_a = 34'(now_x - out_end_x);
                d_a = 34'(in_start_x - out_end_x);
            end
            default:
            begin
                n_a = 34'(now_x - out_start_x);
                d_a = 34'(out_end_x - out_start_x);
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tag_a_reg <= '0;
        else
        begin
            tag_a_reg.valid  <= in_valid;
            tag_a_reg.kind   <= kind_a;
            tag_a_reg.t_zero <= 1'b0;
            tag_a_reg.t_one  <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        n_a_reg <= n_a;
        d_a_reg <= d_a;
    end

    // reversed span flips both signs, then clamp flags
    always_comb
    begin
        if (d_a_reg < 0)
        begin
            n_b = -n_a_reg;
            d_b = -d_a_reg;
        end
        else
        begin
            n_b = n_a_reg;
            d_b = d_a_reg;
        end
        if (d_a_reg == 0)
        begin
            zero_b = n_a_reg < 0;
            one_b  = !(n_a_reg < 0);
        end
        else
        begin
            zero_b = n_b < 0;
            one_b  = n_b > d_b;
        end
        tag_b_next        = tag_a_reg;
        tag_b_next.t_zero = zero_b;
        tag_b_next.t_one  = one_b && !zero_b;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            tag_b_reg <= '0;
        else
            tag_b_reg <= tag_b_next;
    end

    always_ff @(posedge clk)
    begin
        n_b_reg <= n_b[32:0];
        d_b_reg <= d_b[32:0];
    end

    assign tag = tag_b_reg;
    assign num = n_b_reg;
    assign den = d_b_reg;

endmodule

@@ hdl/ecm_div.sv @@
// ----------------------------------------------------------------------------
// ecm_div
// pipelined restoring divider, one quotient bit per stage, num <= den
// ----------------------------------------------------------------------------
module ecm_div
(
    input  logic            clk,
    input  logic            rst_n,
    input  ecm_pkg::tag_t   in_tag,
    input  logic [32:0]     num,
    input  logic [32:0]     den,
    output ecm_pkg::tag_t   out_tag,
    output logic [16:0]     quot
);

    localparam int unsigned NS = ecm_pkg::QBITS;

    logic [33:0]   sh     [NS];
    logic [32:0]   dd     [NS];
    logic          ge     [NS];
    logic [32:0]   rem_next [NS];
    logic [16:0]   q_next [NS];

    logic [32:0]   rem_reg [NS];
    logic [32:0]   d_reg   [NS];
    logic [16:0]   q_reg   [NS];
    ecm_pkg::tag_t tag_reg [NS];

    always_comb
    begin
        for (int i = 0; i < NS; i++)
        begin
            if (i == 0)
            begin
                sh[i] = {1'b0, num};
                dd[i] = den;
            end
            else
            begin
                sh[i] = {rem_reg[i-1], 1'b0};
                dd[i] = d_reg[i-1];
            end
            ge[i] = sh[i] >= {1'b0, dd[i]};
            rem_next[i] = ge[i] ? 33'(sh[i] - {1'b0, dd[i]}) : sh[i][32:0];
            q_next[i] = (i == 0) ? 17'd0 : q_reg[i-1];
            q_next[i][NS-1-i] = ge[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NS; i++)
                tag_reg[i] <= '0;
        end
        else
        begin
            tag_reg[0] <= in_tag;
            for (int i = 1; i < NS; i++)
                tag_reg[i] <= tag_reg[i-1];
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < NS; i++)
        begin
            rem_reg[i] <= rem_next[i];
            d_reg[i]   <= dd[i];
            q_reg[i]   <= q_next[i];
        end
    end

    assign out_tag = tag_reg[NS-1];
    assign quot    = q_reg[NS-1];

endmodule

@@ hdl/ecm_blend.sv @@
// ----------------------------------------------------------------------------
// ecm_blend
// bernstein curve or cross-fade from t, then rounded division by 255; constant items give 1.0
// ----------------------------------------------------------------------------
module ecm_blend
(
    input  logic            clk,
    input  logic            rst_n,
    input  ecm_pkg::tag_t   in_tag,
    input  logic [16:0]     quot,
    input  logic [31:0]     in_curve,
    input  logic [31:0]     out_curve,
    output logic            done,
    output logic [16:0]     multiplier
);

    ecm_pkg::tag_t s0_tag_reg, s1_tag_reg, s2_tag_reg, s3_tag_reg;
    ecm_pkg::tag_t s4_tag_reg, s5_tag_reg, s6_tag_reg;

    logic [16:0] t_next;
    logic [16:0] s0_t_reg, s0_u_reg;
    logic [16:0] s1_t_reg, s1_u_reg;
    logic [33:0] s1_tt_reg, s1_uu_reg, s1_ut_reg;
    logic [23:0] s1_f1_reg, s1_f2_reg;
    logic [48:0] s2_ttt_reg, s2_uut_reg, s2_utt_reg, s2_uuu_reg;
    logic [23:0] s2_x_reg;
    logic [31:0] s3_curve;
    logic [9:0]  s3_k1, s3_k2;
    logic [55:0] s3_c0_reg, s3_c1_reg, s3_c2_reg, s3_c3_reg;
    logic [23:0] s3_x_reg;
    logic [55:0] s4_s01_reg, s4_s23_reg;
    logic [23:0] s4_x_reg;
    logic [56:0] s5_sum;
    logic [23:0] s5_y_reg;
    logic [49:0] s6_prod_reg;
    logic        done_reg;
    logic [16:0] mult_reg;

    always_comb
    begin
        if (in_tag.t_one)
            t_next = ecm_pkg::ONE_Q16;
        else if (in_tag.t_zero)
            t_next = 17'd0;
        else
            t_next = quot;
    end

    assign s3_curve = (s2_tag_reg.kind == ecm_pkg::KIND_IN) ? in_curve : out_curve;
    assign s3_k1    = 10'(s3_curve[15:8]) * 10'd3;
    assign s3_k2    = 10'(s3_curve[23:16]) * 10'd3;
    assign s5_sum   = 57'(s4_s01_reg) + 57'(s4_s23_reg) + ecm_pkg::CURVE_RND;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_tag_reg <= '0;
            s1_tag_reg <= '0;
            s2_tag_reg <= '0;
            s3_tag_reg <= '0;
            s4_tag_reg <= '0;
            s5_tag_reg <= '0;
            s6_tag_reg <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            s0_tag_reg <= in_tag;
            s1_tag_reg <= s0_tag_reg;
            s2_tag_reg <= s1_tag_reg;
            s3_tag_reg <= s2_tag_reg;
            s4_tag_reg <= s3_tag_reg;
            s5_tag_reg <= s4_tag_reg;
            s6_tag_reg <= s5_tag_reg;
            done_reg   <= s6_tag_reg.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        // t and its complement
        s0_t_reg <= t_next;
        s0_u_reg <= 17'(ecm_pkg::ONE_Q16 - t_next);
        // squares, and the two cross-fade products
        s1_t_reg  <= s0_t_reg;
        s1_u_reg  <= s0_u_reg;
        s1_tt_reg <= 34'(s0_t_reg) * 34'(s0_t_reg);
        s1_uu_reg <= 34'(s0_u_reg) * 34'(s0_u_reg);
        s1_ut_reg <= 34'(s0_u_reg) * 34'(s0_t_reg);
        s1_f1_reg <= 24'(25'(s0_u_reg) * 25'(out_curve[31:24]));
        s1_f2_reg <= 24'(25'(s0_t_reg) * 25'(in_curve[7:0]));
        // cubes
        s2_ttt_reg <= 49'(51'(s1_tt_reg) * 51'(s1_t_reg));
        s2_utt_reg <= 49'(51'(s1_ut_reg) * 51'(s1_t_reg));
        s2_uut_reg <= 49'(51'(s1_uu_reg) * 51'(s1_t_reg));
        s2_uuu_reg <= 49'(51'(s1_uu_reg) * 51'(s1_u_reg));
        s2_x_reg   <= s1_f1_reg + s1_f2_reg + ecm_pkg::FADE_RND;
        // weighted by the control bytes
        s3_c0_reg <= 56'(59'(s2_uuu_reg) * 59'(s3_curve[7:0]));
        s3_c1_reg <= 56'(59'(s2_uut_reg) * 59'(s3_k1));
        s3_c2_reg <= 56'(59'(s2_utt_reg) * 59'(s3_k2));
        s3_c3_reg <= 56'(59'(s2_ttt_reg) * 59'(s3_curve[31:24]));
        s3_x_reg  <= s2_x_reg;
        // partial sums
        s4_s01_reg <= s3_c0_reg + s3_c1_reg;
        s4_s23_reg <= s3_c2_reg + s3_c3_reg;
        s4_x_reg   <= s3_x_reg;
        // value to divide by 255
        if (s4_tag_reg.kind == ecm_pkg::KIND_FADE)
            s5_y_reg <= s4_x_reg;
        else
            s5_y_reg <= s5_sum[55:32];
        // reciprocal multiply
        s6_prod_reg <= 50'(s5_y_reg) * 50'(ecm_pkg::RECIP_255);
        // result
        if (s6_tag_reg.kind == ecm_pkg::KIND_CONST)
            mult_reg <= ecm_pkg::ONE_Q16;
        else
            mult_reg <= s6_prod_reg[ecm_pkg::RECIP_SHIFT +: 17];
    end

    assign done       = done_reg;
    assign multiplier = mult_reg;

endmodule

@@ hdl/ease_curve_multiplier.sv @@
// ----------------------------------------------------------------------------
// ease_curve_multiplier
// animation blend multiplier from two cubic ease curves and a cross-fade
// ----------------------------------------------------------------------------
//
//  channel   signals                                    direction
//  -------   ----------------------------------------   ---------
//  item in   start, busy, now_clock[31:0]               in / out
//  result    done, multiplier[16:0]                     out
//  config    cfg_valid, cfg_ready, cfg_index, cfg_data  in / out
//
//  one item a cycle; each item passes 2 span stages, 17 divider stages of one
//  quotient bit each and 8 blend stages before its result appears
//  busy never rises and cfg_ready is always high: the pipeline never stalls,
//  as the receiver cannot hold a result off
//  rst_n clears the valid bits and loads register reset values at once
//  registers are sampled live, so write them only with the pipeline empty
//
module ease_curve_multiplier
(
    input  logic               clk,
    input  logic               rst_n,
    // item in
    input  logic               start,
    output logic               busy,
    input  logic signed [31:0] now_clock,
    // result
    output logic               done,
    output logic [16:0]        multiplier,
    // configuration writes
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [2:0]         cfg_index,
    input  logic [31:0]        cfg_data
);

    ecm_pkg::cfg_t cfg_reg;
    ecm_pkg::tag_t span_tag;
    logic [32:0]   span_num;
    logic [32:0]   span_den;
    ecm_pkg::tag_t div_tag;
    logic [16:0]   div_quot;
    logic          accept;

    assign busy      = 1'b0;
    assign cfg_ready = 1'b1;
    assign accept    = start && !busy;

    // register file, index decode
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.in_start  <= '0;
            cfg_reg.in_end    <= '0;
            cfg_reg.out_start <= '0;
            cfg_reg.out_end   <= '0;
            cfg_reg.in_curve  <= ecm_pkg::IN_CURVE_RESET;
            cfg_reg.out_curve <= ecm_pkg::OUT_CURVE_RESET;
            cfg_reg.mode      <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                ecm_pkg::REG_IN_START:  cfg_reg.in_start  <= cfg_data;
                ecm_pkg::REG_IN_END:    cfg_reg.in_end    <= cfg_data;
                ecm_pkg::REG_OUT_START: cfg_reg.out_start <= cfg_data;
                ecm_pkg::REG_OUT_END:   cfg_reg.out_end   <= cfg_data;
                ecm_pkg::REG_IN_CURVE:  cfg_reg.in_curve  <= cfg_data;
                ecm_pkg::REG_OUT_CURVE: cfg_reg.out_curve <= cfg_data;
                ecm_pkg::REG_MODE:      cfg_reg.mode      <= cfg_data[1:0];
                default:                ;
            endcase
        end
    end

    // segment choice and span terms
    ecm_span u_span
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (accept),
        .now_clock (now_clock),
        .cfg       (cfg_reg),
        .tag       (span_tag),
        .num       (span_num),
        .den       (span_den)
    );

    // t or cross-fade fraction in q1.16
    ecm_div u_div
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_tag  (span_tag),
        .num     (span_num),
        .den     (span_den),
        .out_tag (div_tag),
        .quot    (div_quot)
    );

    // curve evaluation and rounding
    ecm_blend u_blend
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_tag     (div_tag),
        .quot       (div_quot),
        .in_curve   (cfg_reg.in_curve),
        .out_curve  (cfg_reg.out_curve),
        .done       (done),
        .multiplier (multiplier)
    );

endmodule
